### design/sha_pkg.sv
// Shared types, result codes and sizing functions of the slot handle allocator.
package sha_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_REMOVE  = 2'd1,
		KIND_GET     = 2'd2,
		KIND_ITERATE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FULL   = 2'd1,
		STATUS_RANGE  = 2'd2,
		STATUS_DFREE  = 2'd3
	} status_t;

	// Slot count rounded up to the next power of two, at most 256.
	function automatic int cap_of(input int slots);
		int c;
		c = 1;
		for (int i = 0; i < 8; i++) begin
			if (c < slots) begin
				c = c * 2;
			end
		end
		return c;
	endfunction

	// Index width for a table of cap entries; at least one bit.
	function automatic int idx_width(input int cap);
		int w;
		w = (cap <= 1) ? 1 : $clog2(cap);
		return w;
	endfunction

endpackage

### design/sha_ring.sv
// Ring of slot numbers: one synchronous memory with per-entry written flags.
module sha_ring #(
	parameter int SLOTS = 64
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   rd_en,
	input  logic [sha_pkg::idx_width(sha_pkg::cap_of(SLOTS))-1:0] rd_addr,
	output logic [sha_pkg::idx_width(sha_pkg::cap_of(SLOTS))-1:0] rd_slot,
	input  logic                                                   wr_en,
	input  logic [sha_pkg::idx_width(sha_pkg::cap_of(SLOTS))-1:0] wr_addr,
	input  logic [sha_pkg::idx_width(sha_pkg::cap_of(SLOTS))-1:0] wr_data
);
	import sha_pkg::*;

	localparam int CAP = cap_of(SLOTS);
	localparam int IW  = idx_width(CAP);

	logic [IW-1:0]  ring_mem [CAP];
	logic [CAP-1:0] written_q;
	logic [IW-1:0]  rd_data_q;
	logic [IW-1:0]  rd_addr_q;
	logic           rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// An entry never written reads as its own index, which is the reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_slot = rd_written_q ? rd_data_q : rd_addr_q;

endmodule

### design/slot_handle_allocator.sv
// Top level of the slot handle allocator: request decode, slot table and result register.
//
// Usage: a request item (kind, payload, slot, position) enters on req_valid while
// req_stall is low. Insert takes the slot named by the ring entry at the allocation
// counter, remove returns a slot to the ring at the free counter, get reads a busy
// slot's payload and iterate reads the slot at a given ring position.
// Each request gives exactly one response item on rsp_valid / rsp_stall, carrying
// status, slot_out, data_out, found and both 32-bit position counters after the step.
// Timing: a request is accepted, the ring is read in the accept cycle, the slot table
// is read and updated in the next cycle, and the payload read returns in the cycle after.
// The response register is loaded in the final step once it is free; a new request is
// taken only when the item in flight has passed the ring read, then the slot table read,
// both through synchronous memories with registered read data, and the response load.
// A request can be accepted while the previous response still waits on rsp_stall;
// it then holds in its last step until the response register frees.
// Reset clears the busy marks, the ring's written flags and both counters at once;
// no clearing pass is needed, so the block takes requests right after reset.
module slot_handle_allocator #(
	parameter int SLOTS         = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] payload,
	input  logic [7:0]  slot,
	input  logic [31:0] position,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [7:0]  slot_out,
	output logic [31:0] data_out,
	output logic        found,
	output logic [31:0] alloc_count,
	output logic [31:0] free_count
);
	import sha_pkg::*;

	localparam int CAP = cap_of(SLOTS);
	localparam int IW  = idx_width(CAP);
	// Stored payload width: the ports carry 32 bits, so wider settings are cut to 32.
	localparam int SW  = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
	localparam logic [IW-1:0] IDX_MASK = IW'(CAP - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RING,
		S_DATA
	} state_t;

	state_t state_q;

	// Request fields held for the item in flight.
	kind_t         kind_s1;
	logic [SW-1:0] payload_s1;
	logic [7:0]    slot_s1;

	// Result fields decided in the table step.
	status_t       status_s2;
	logic [IW-1:0] slot_out_s2;
	logic          found_s2;

	// Slot table: payload memory, with the busy marks acting as its valid bits.
	logic [SW-1:0]  pay_mem [CAP];
	logic [SW-1:0]  pay_rd_q;
	logic [CAP-1:0] busy_q;
	logic [31:0]    alloc_q;
	logic [31:0]    free_q;

	logic          accept;
	logic [IW-1:0] ring_rd_addr;
	logic [IW-1:0] ring_slot;
	logic          ring_wr_en;
	logic [IW-1:0] ring_wr_addr;
	logic [IW-1:0] slot_sel;
	logic          slot_in_range;
	logic [IW-1:0] target;
	logic          busy_hit;
	logic          insert_ok;
	logic          remove_ok;
	status_t       status_next;
	logic [IW-1:0] slot_out_next;
	logic          found_next;
	logic [31:0]   data_ext;
	logic          rsp_free;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid || !rsp_stall;

	// The ring is addressed straight from the request so its data is ready next cycle.
	assign ring_rd_addr = ((kind_t'(kind) == KIND_ITERATE) ? position[IW-1:0]
	                                                        : alloc_q[IW-1:0]) & IDX_MASK;

	sha_ring #(
		.SLOTS (SLOTS)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (ring_rd_addr),
		.rd_slot (ring_slot),
		.wr_en   (ring_wr_en),
		.wr_addr (ring_wr_addr),
		.wr_data (slot_sel)
	);

	// Table step: decode the request against the busy marks.
	always_comb begin
		slot_sel      = slot_s1[IW-1:0] & IDX_MASK;
		slot_in_range = ({1'b0, slot_s1} < 9'(CAP));
		if (kind_s1 == KIND_INSERT || kind_s1 == KIND_ITERATE) begin
			target = ring_slot & IDX_MASK;
		end else begin
			target = slot_sel;
		end
		busy_hit      = busy_q[target];
		insert_ok     = 1'b0;
		remove_ok     = 1'b0;
		status_next   = STATUS_OK;
		slot_out_next = '0;
		found_next    = 1'b0;
		case (kind_s1)
			KIND_INSERT: begin
				if (busy_hit) begin
					status_next = STATUS_FULL;
				end else begin
					insert_ok     = 1'b1;
					slot_out_next = target;
				end
			end
			KIND_REMOVE: begin
				if (!slot_in_range) begin
					status_next = STATUS_RANGE;
				end else if (!busy_hit) begin
					status_next = STATUS_DFREE;
				end else begin
					remove_ok = 1'b1;
				end
			end
			KIND_GET: begin
				if (!slot_in_range) begin
					status_next = STATUS_RANGE;
				end else begin
					found_next = busy_hit;
				end
			end
			default: begin
				slot_out_next = target;
				found_next    = busy_hit;
			end
		endcase
	end

	assign ring_wr_en   = (state_q == S_RING) && remove_ok;
	assign ring_wr_addr = free_q[IW-1:0] & IDX_MASK;

	always_comb begin
		data_ext         = '0;
		data_ext[SW-1:0] = pay_rd_q;
	end

	// Payload memory: written on a good insert, read for every item in the table step.
	always_ff @(posedge clk) begin
		if (state_q == S_RING) begin
			if (insert_ok) begin
				pay_mem[target] <= payload_s1;
			end
			pay_rd_q <= pay_mem[target];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			alloc_q <= '0;
			free_q  <= '0;
		end else if (state_q == S_RING) begin
			if (insert_ok) begin
				busy_q[target] <= 1'b1;
				alloc_q        <= alloc_q + 32'd1;
			end
			if (remove_ok) begin
				busy_q[target] <= 1'b0;
				free_q         <= free_q + 32'd1;
			end
		end
	end

	// Request capture and decided result fields; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind_t'(kind);
			payload_s1 <= payload[SW-1:0];
			slot_s1    <= slot;
		end
		if (state_q == S_RING) begin
			status_s2   <= status_next;
			slot_out_s2 <= slot_out_next;
			found_s2    <= found_next;
		end
	end

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid   <= 1'b0;
			status      <= STATUS_OK;
			slot_out    <= '0;
			data_out    <= '0;
			found       <= 1'b0;
			alloc_count <= '0;
			free_count  <= '0;
		end else begin
			if (state_q == S_DATA && rsp_free) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RING;
					end
				end
				S_RING: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					if (rsp_free) begin
						status      <= status_s2;
						slot_out    <= 8'(slot_out_s2);
						data_out    <= found_s2 ? data_ext : 32'd0;
						found       <= found_s2;
						alloc_count <= alloc_q;
						free_count  <= free_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The number of busy slots always equals the distance between the counters.
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(alloc_q - free_q) == 32'($countones(busy_q)))
		else $error("busy mark count differs from counter distance");

	// A response is only loaded from the final step of an item.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_DATA))
		else $error("response loaded outside the final step");

	// The allocation counter only moves on an insert in the table step.
	a_alloc_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(alloc_q) |-> $past(state_q == S_RING && kind_s1 == KIND_INSERT))
		else $error("allocation counter moved without an insert");

	// A slot returned to the ring is no longer busy afterwards.
	a_remove_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ring_wr_en |=> !busy_q[$past(slot_sel)])
		else $error("removed slot still busy");

endmodule

### dv/tb.sv
// Self-checking testbench for the slot handle allocator: directed cases, table fill and random traffic.
`timescale 1ns / 100ps

module tb;
	import sha_pkg::*;

	// The block under test is built with its default of 64 slots, so the table,
	// the ring and the slot index are all sized for 64 entries (6 index bits).
	localparam int TABLE_SLOTS = 64;
	localparam int ITEM_TARGET = 1250;

	// One expected response item, held in acceptance order.
	typedef struct {
		status_t     st;
		logic [7:0]  slot_num;
		logic [31:0] data;
		logic        hit;
		logic [31:0] alloc_cnt;
		logic [31:0] free_cnt;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  kind = 2'd0;
	logic [31:0] payload = 32'd0;
	logic [7:0]  slot = 8'd0;
	logic [31:0] position = 32'd0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [1:0]  status;
	logic [7:0]  slot_out;
	logic [31:0] data_out;
	logic        found;
	logic [31:0] alloc_count;
	logic [31:0] free_count;

	// Shadow copy of the allocator state, updated at each accepted request item.
	logic [31:0] contents [TABLE_SLOTS];
	logic        occupied [TABLE_SLOTS];
	logic        touched [TABLE_SLOTS];
	logic [5:0]  ring [TABLE_SLOTS];
	logic [31:0] alloc_pos;
	logic [31:0] free_pos;

	response_t pending_responses [$];

	int items_sent;
	int responses_checked;
	int mismatches;
	int n_inserted;
	int n_full;
	int n_removed;
	int n_range;
	int n_dfree;
	int n_hits;
	int rsp_hold = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	slot_handle_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.payload     (payload),
		.slot        (slot),
		.position    (position),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.slot_out    (slot_out),
		.data_out    (data_out),
		.found       (found),
		.alloc_count (alloc_count),
		.free_count  (free_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case the block hangs; far beyond the slowest correct run.
	initial begin
		#15_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Idle stretches for both sides: mostly from the shortest of three ranges, now and then from the longest.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Applies one request to the shadow state and returns the response it should produce.
	function automatic response_t compute_response(kind_t k, logic [31:0] pay, logic [7:0] sl,
			logic [31:0] pos);
		response_t r;
		logic [5:0] s;
		r = '{st: STATUS_OK, slot_num: 8'd0, data: 32'd0, hit: 1'b0,
			alloc_cnt: 32'd0, free_cnt: 32'd0};
		case (k)
			KIND_INSERT: begin
				// The ring entry at the allocation position names the slot to take;
				// if that slot is still busy the table is full and nothing moves.
				s = ring[alloc_pos[5:0]];
				if (occupied[s]) begin
					r.st = STATUS_FULL;
					n_full++;
				end else begin
					contents[s] = pay;
					occupied[s] = 1'b1;
					touched[s] = 1'b1;
					r.slot_num = {2'b00, s};
					alloc_pos = alloc_pos + 32'd1;
					n_inserted++;
				end
			end
			KIND_REMOVE: begin
				if (sl >= TABLE_SLOTS) begin
					r.st = STATUS_RANGE;
					n_range++;
				end else if (!occupied[sl[5:0]]) begin
					r.st = STATUS_DFREE;
					n_dfree++;
				end else begin
					ring[free_pos[5:0]] = sl[5:0];
					occupied[sl[5:0]] = 1'b0;
					contents[sl[5:0]] = 32'd0;
					free_pos = free_pos + 32'd1;
					n_removed++;
				end
			end
			KIND_GET: begin
				if (sl >= TABLE_SLOTS) begin
					r.st = STATUS_RANGE;
					n_range++;
				end else if (occupied[sl[5:0]]) begin
					r.hit = 1'b1;
					r.data = contents[sl[5:0]];
					n_hits++;
				end
			end
			default: begin
				s = ring[pos[5:0]];
				r.slot_num = {2'b00, s};
				if (occupied[s]) begin
					r.hit = 1'b1;
					r.data = contents[s];
					n_hits++;
				end
			end
		endcase
		r.alloc_cnt = alloc_pos;
		r.free_cnt = free_pos;
		return r;
	endfunction

	// Returns a random busy slot, or -1 when the table is empty.
	function automatic int random_busy_slot();
		int picks [$];
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (occupied[i]) begin
				picks.push_back(i);
			end
		end
		if (picks.size() == 0) begin
			return -1;
		end
		return picks[$urandom_range(0, picks.size() - 1)];
	endfunction

	// A random ring position whose entry names a slot that has been written at least once,
	// so that the payload store is never read where it holds no defined value.
	function automatic logic [31:0] iterate_position();
		logic [31:0] pos;
		pos = $urandom();
		if (!touched[ring[pos[5:0]]]) begin
			for (int e = 0; e < TABLE_SLOTS; e++) begin
				if (touched[ring[e]]) begin
					pos[5:0] = e[5:0];
				end
			end
		end
		return pos;
	endfunction

	// Presents one request item, holds it until accepted, records its expected response,
	// then maybe leaves the request side idle for a while.
	task automatic send_item(kind_t k, logic [31:0] pay, logic [7:0] sl, logic [31:0] pos);
		int gap;
		req_valid <= 1'b1;
		kind <= k;
		payload <= pay;
		slot <= sl;
		position <= pos;
		do begin
			@(posedge clk);
		end while (req_stall);
		pending_responses.push_back(compute_response(k, pay, sl, pos));
		items_sent++;
		if (tx_idle_on && $urandom_range(0, 2) == 0) begin
			gap = idle_length();
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Response checker and response-side stall generator.
	always @(posedge clk) begin
		response_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: response item with nothing expected: st=%0d slot=%0d data=%h",
						$realtime, status, slot_out, data_out);
				end
			end else begin
				want = pending_responses.pop_front();
				responses_checked++;
				if (status !== want.st || slot_out !== want.slot_num || data_out !== want.data ||
						found !== want.hit || alloc_count !== want.alloc_cnt ||
						free_count !== want.free_cnt) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch expected st=%0d slot=%0d data=%h found=%0b alloc=%0d free=%0d",
							$realtime, want.st, want.slot_num, want.data, want.hit,
							want.alloc_cnt, want.free_cnt);
						$display("%0t:          actual   st=%0d slot=%0d data=%h found=%0b alloc=%0d free=%0d",
							$realtime, status, slot_out, data_out, found, alloc_count, free_count);
					end
				end
			end
		end
		if (rsp_hold > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold--;
		end else begin
			rsp_stall <= 1'b0;
			if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				rsp_hold = idle_length();
			end
		end
	end

	// Inserts with all-zero, all-one and alternating payloads take slots 0 to 3 in ring order.
	task automatic test_insert_extremes();
		send_item(KIND_INSERT, 32'h0000_0000, 8'($urandom_range(0, 255)), $urandom());
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 8'($urandom_range(0, 255)), $urandom());
		send_item(KIND_INSERT, 32'hAAAA_AAAA, 8'($urandom_range(0, 255)), $urandom());
		send_item(KIND_INSERT, 32'h5555_5555, 8'($urandom_range(0, 255)), $urandom());
	endtask

	// A good remove, the same slot again as a double free, slot numbers past the table,
	// and a slot that was never taken.
	task automatic test_remove_checks();
		send_item(KIND_REMOVE, $urandom(), 8'd1, $urandom());
		send_item(KIND_REMOVE, $urandom(), 8'd1, $urandom());
		send_item(KIND_REMOVE, $urandom(), 8'd64, $urandom());
		send_item(KIND_REMOVE, $urandom(), 8'd255, $urandom());
		send_item(KIND_REMOVE, $urandom(), 8'd63, $urandom());
	endtask

	// Get of busy slots, of a freed slot and of slot numbers past the table.
	task automatic test_get_by_slot();
		send_item(KIND_GET, $urandom(), 8'd0, $urandom());
		send_item(KIND_GET, $urandom(), 8'd2, $urandom());
		send_item(KIND_GET, $urandom(), 8'd1, $urandom());
		send_item(KIND_GET, $urandom(), 8'd64, $urandom());
		send_item(KIND_GET, $urandom(), 8'd255, $urandom());
	endtask

	// Ring reads: the freed slot written back at position 0, busy slots through positions
	// with high counter bits set, and a slot taken after the ring was rewritten.
	task automatic test_iterate_ring();
		send_item(KIND_ITERATE, $urandom(), 8'($urandom_range(0, 255)), 32'h0000_0000);
		send_item(KIND_ITERATE, $urandom(), 8'($urandom_range(0, 255)), 32'hFFFF_FFC2);
		send_item(KIND_ITERATE, $urandom(), 8'($urandom_range(0, 255)), 32'h8000_0003);
		send_item(KIND_INSERT, 32'h1234_5678, 8'($urandom_range(0, 255)), $urandom());
		send_item(KIND_ITERATE, $urandom(), 8'($urandom_range(0, 255)), 32'h7FFF_FFC4);
	endtask

	// Fills every slot, inserts into the full table, reads around, then drains most of it.
	task automatic test_full_table();
		int s;
		while (alloc_pos - free_pos < TABLE_SLOTS) begin
			send_item(KIND_INSERT, $urandom(), 8'($urandom_range(0, 255)), $urandom());
		end
		repeat (3) send_item(KIND_INSERT, $urandom(), 8'($urandom_range(0, 255)), $urandom());
		repeat (8) send_item(KIND_ITERATE, $urandom(), 8'($urandom_range(0, 255)),
			iterate_position());
		repeat (8) begin
			s = random_busy_slot();
			send_item(KIND_GET, $urandom(), s[7:0], $urandom());
		end
		repeat (48) begin
			s = random_busy_slot();
			send_item(KIND_REMOVE, $urandom(), s[7:0], $urandom());
		end
	endtask

	// Mixed traffic in phases that lean toward filling, draining or neither, so the table
	// swings between empty and full; a share of removes and gets are noise.
	task automatic test_random_traffic(int target);
		int n;
		int lean;
		int r;
		int s;
		int ins_w;
		int rem_w;
		int mode;
		logic [7:0] sl;
		n = 0;
		lean = 0;
		while (items_sent < target) begin
			if (n % 100 == 0) begin
				lean = $urandom_range(0, 2);
			end
			if (n % 150 == 0) begin
				// Some phases run one or both sides with no idling at all.
				mode = $urandom_range(0, 3);
				tx_idle_on = (mode == 0 || mode == 2);
				rx_idle_on = (mode == 0 || mode == 1);
			end
			n++;
			ins_w = (lean == 0) ? 55 : (lean == 1) ? 30 : 10;
			rem_w = (lean == 0) ? 10 : (lean == 1) ? 30 : 50;
			r = $urandom_range(0, 99);
			if (r < ins_w) begin
				send_item(KIND_INSERT, $urandom(), 8'($urandom_range(0, 255)), $urandom());
			end else if (r < ins_w + rem_w) begin
				s = random_busy_slot();
				if (s < 0 || $urandom_range(0, 99) < 15) begin
					sl = 8'($urandom_range(0, 255));
				end else begin
					sl = s[7:0];
				end
				send_item(KIND_REMOVE, $urandom(), sl, $urandom());
			end else if (r < ins_w + rem_w + (100 - ins_w - rem_w) / 2) begin
				s = random_busy_slot();
				if (s < 0 || $urandom_range(0, 99) < 30) begin
					sl = 8'($urandom_range(0, 255));
					if (sl < TABLE_SLOTS && !touched[sl[5:0]]) begin
						sl = sl | 8'h40;
					end
				end else begin
					sl = s[7:0];
				end
				send_item(KIND_GET, $urandom(), sl, $urandom());
			end else begin
				send_item(KIND_ITERATE, $urandom(), 8'($urandom_range(0, 255)),
					iterate_position());
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			contents[i] = 32'd0;
			occupied[i] = 1'b0;
			touched[i] = 1'b0;
			ring[i] = i[5:0];
		end
		alloc_pos = 32'd0;
		free_pos = 32'd0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_insert_extremes();
		test_remove_checks();
		test_get_by_slot();
		test_iterate_ring();
		test_full_table();
		test_random_traffic(ITEM_TARGET);

		// Let every outstanding response drain, then keep clocking for strays.
		req_valid <= 1'b0;
		while (pending_responses.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);

		$display("run covered %0d request items: %0d inserts, %0d on a full table, %0d removes",
			items_sent, n_inserted, n_full, n_removed);
		$display("%0d range errors, %0d double frees, %0d lookup hits, %0d responses checked",
			n_range, n_dfree, n_hits, responses_checked);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
design/sha_pkg.sv
design/sha_ring.sv
design/slot_handle_allocator.sv
dv/tb.sv
